[design/ubx_nav_frame_parser_macros.svh]
`ifndef UBX_NAV_FRAME_PARSER_MACROS_SVH
`define UBX_NAV_FRAME_PARSER_MACROS_SVH

// condition must never hold outside reset
`define UBXNAV_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define UBXNAV_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[design/ubxnav_pkg.sv]
`timescale 1ns / 1ps

package ubxnav_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;
    localparam logic [7:0] ID_POSLLH   = 8'h02;
    localparam logic [7:0] ID_STATUS   = 8'h03;
    localparam logic [7:0] ID_SOL      = 8'h06;
    localparam logic [7:0] ID_VELNED   = 8'h12;
    localparam logic [7:0] FIX_TYPE_3D = 8'd3;

    localparam logic REG_MAX_PAYLOAD = 1'b0;
    localparam logic REG_COURSE_WRAP = 1'b1;

    localparam logic [9:0]  MAX_PAYLOAD_RESET = 10'd464;
    localparam logic [15:0] COURSE_WRAP_RESET = 16'd100;

    localparam int CMDQ_DEPTH = 2;
    localparam int SLOT_COUNT = 12;

    typedef enum logic [1:0] {
        KIND_POSLLH = 2'd0,
        KIND_STATUS = 2'd1,
        KIND_SOL    = 2'd2,
        KIND_VELNED = 2'd3
    } kind_t;

    typedef logic [5:0] off_t;
    typedef logic [3:0] slot_idx_t;

    localparam off_t OFF_LON       = 6'd4;
    localparam off_t OFF_HMSL      = 6'd16;
    localparam off_t OFF_STAT_TYPE = 6'd4;
    localparam off_t OFF_SOL_TYPE  = 6'd10;
    localparam off_t OFF_SOL_PDOP  = 6'd44;
    localparam off_t OFF_SOL_SATS  = 6'd47;
    localparam off_t OFF_VEL_SPEED = 6'd20;

    // reciprocal multipliers, exact for any 32-bit magnitude
    localparam logic [31:0] RECIP_MM      = 32'd274877907;
    localparam logic [31:0] RECIP_HEADING = 32'd3518437209;
    localparam int SHIFT_MM      = 38;
    localparam int SHIFT_HEADING = 45;
    localparam int ALT_Q_W       = 22;
    localparam int HEAD_Q_W      = 18;

    localparam logic signed [HEAD_Q_W:0] COURSE_HI   = 19'sd3600;
    localparam logic signed [HEAD_Q_W:0] COURSE_LO   = -19'sd1800;
    localparam logic signed [HEAD_Q_W:0] COURSE_HALF = 19'sd1800;
    localparam logic signed [HEAD_Q_W:0] COURSE_FULL = 19'sd3600;

    typedef struct packed {
        logic empty;
        logic full;
    } cmdq_stat_t;

    typedef struct packed {
        logic reading;
    } back_stat_t;

    function automatic logic id_known(logic [7:0] id);
        return (id == ID_POSLLH) || (id == ID_STATUS) || (id == ID_SOL) || (id == ID_VELNED);
    endfunction

    function automatic kind_t id_kind(logic [7:0] id);
        kind_t k;
        case (id)
            ID_STATUS: k = KIND_STATUS;
            ID_SOL:    k = KIND_SOL;
            ID_VELNED: k = KIND_VELNED;
            default:   k = KIND_POSLLH;
        endcase
        return k;
    endfunction

    function automatic slot_idx_t read_last(kind_t kind);
        slot_idx_t n;
        case (kind)
            KIND_POSLLH: n = 4'd11;
            KIND_STATUS: n = 4'd1;
            KIND_SOL:    n = 4'd4;
            KIND_VELNED: n = 4'd7;
            default:     n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic off_t read_offset(kind_t kind, slot_idx_t idx);
        off_t off;
        case (kind)
            KIND_POSLLH:
            begin
                if (idx < 4'd8)
                begin
                    off = OFF_LON + off_t'(idx);
                end
                else
                begin
                    off = (OFF_HMSL - 6'd8) + off_t'(idx);
                end
            end
            KIND_STATUS: off = OFF_STAT_TYPE + off_t'(idx);
            KIND_SOL:
            begin
                if (idx < 4'd2)
                begin
                    off = OFF_SOL_TYPE + off_t'(idx);
                end
                else if (idx < 4'd4)
                begin
                    off = (OFF_SOL_PDOP - 6'd2) + off_t'(idx);
                end
                else
                begin
                    off = OFF_SOL_SATS;
                end
            end
            KIND_VELNED: off = OFF_VEL_SPEED + off_t'(idx);
            default:     off = OFF_LON;
        endcase
        return off;
    endfunction

endpackage

[design/ubxnav_front.sv]
`timescale 1ns / 1ps

module ubxnav_front #(
    parameter int STORE_BYTES = 512,
    localparam int AW = $clog2(STORE_BYTES)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             data_byte,
    input  logic [9:0]             max_payload,
    input  ubxnav_pkg::cmdq_stat_t cmdq_stat,
    input  ubxnav_pkg::back_stat_t back_stat,
    output logic                   cmd_push,
    output ubxnav_pkg::kind_t      cmd_kind,
    output logic                   st_we,
    output logic [AW-1:0]          st_waddr,
    output logic [7:0]             st_wdata
);

    typedef enum logic [3:0] {
        F_HUNT,
        F_SYNC2,
        F_CLASS,
        F_ID,
        F_LEN_LO,
        F_LEN_HI,
        F_PAYLOAD,
        F_CK_A,
        F_CK_B
    } f_state_t;

    f_state_t    state_reg;
    logic [7:0]  sum_a_reg;
    logic [7:0]  sum_b_reg;
    logic [7:0]  msg_id_reg;
    logic [7:0]  len_lo_reg;
    logic [9:0]  len_reg;
    logic [9:0]  rcv_reg;

    logic        accept;
    logic [7:0]  sum_a_next;
    logic [7:0]  sum_b_next;
    logic [15:0] len_word;
    logic [9:0]  rcv_next;

    assign in_stall = ((state_reg == F_PAYLOAD) && (!cmdq_stat.empty || back_stat.reading))
                   || ((state_reg == F_CK_B) && cmdq_stat.full);
    assign accept   = in_valid && !in_stall;

    assign sum_a_next = sum_a_reg + data_byte;
    assign sum_b_next = sum_b_reg + sum_a_next;
    assign len_word   = {data_byte, len_lo_reg};
    assign rcv_next   = rcv_reg + 10'd1;

    assign st_we    = accept && (state_reg == F_PAYLOAD)
                   && ({1'b0, rcv_reg} < 11'(STORE_BYTES));
    assign st_waddr = rcv_reg[AW-1:0];
    assign st_wdata = data_byte;

    assign cmd_push = accept && (state_reg == F_CK_B) && (data_byte == sum_b_reg)
                   && ubxnav_pkg::id_known(msg_id_reg);
    assign cmd_kind = ubxnav_pkg::id_kind(msg_id_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_HUNT;
            sum_a_reg  <= 8'd0;
            sum_b_reg  <= 8'd0;
            msg_id_reg <= 8'd0;
            len_lo_reg <= 8'd0;
            len_reg    <= 10'd0;
            rcv_reg    <= 10'd0;
        end
        else if (accept)
        begin
            case (state_reg)
                F_HUNT:
                begin
                    state_reg <= (data_byte == ubxnav_pkg::SYNC_FIRST) ? F_SYNC2 : F_HUNT;
                end
                F_SYNC2:
                begin
                    if (data_byte == ubxnav_pkg::SYNC_SECOND)
                    begin
                        state_reg <= F_CLASS;
                    end
                    else
                    begin
                        state_reg <= (data_byte == ubxnav_pkg::SYNC_FIRST) ? F_SYNC2 : F_HUNT;
                    end
                end
                F_CLASS:
                begin
                    sum_a_reg <= data_byte;
                    sum_b_reg <= data_byte;
                    state_reg <= F_ID;
                end
                F_ID:
                begin
                    sum_a_reg  <= sum_a_next;
                    sum_b_reg  <= sum_b_next;
                    msg_id_reg <= data_byte;
                    state_reg  <= F_LEN_LO;
                end
                F_LEN_LO:
                begin
                    sum_a_reg  <= sum_a_next;
                    sum_b_reg  <= sum_b_next;
                    len_lo_reg <= data_byte;
                    state_reg  <= F_LEN_HI;
                end
                F_LEN_HI:
                begin
                    sum_a_reg <= sum_a_next;
                    sum_b_reg <= sum_b_next;
                    rcv_reg   <= 10'd0;
                    len_reg   <= len_word[9:0];
                    if (len_word > {6'd0, max_payload})
                    begin
                        state_reg <= F_HUNT;
                    end
                    else if (len_word == 16'd0)
                    begin
                        state_reg <= F_CK_A;
                    end
                    else
                    begin
                        state_reg <= F_PAYLOAD;
                    end
                end
                F_PAYLOAD:
                begin
                    sum_a_reg <= sum_a_next;
                    sum_b_reg <= sum_b_next;
                    rcv_reg   <= rcv_next;
                    if (rcv_next == len_reg)
                    begin
                        state_reg <= F_CK_A;
                    end
                end
                F_CK_A:
                begin
                    state_reg <= (data_byte == sum_a_reg) ? F_CK_B : F_HUNT;
                end
                F_CK_B:
                begin
                    state_reg <= F_HUNT;
                end
                default:
                begin
                    state_reg <= F_HUNT;
                end
            endcase
        end
    end

endmodule

[design/ubxnav_cmdq.sv]
`timescale 1ns / 1ps
`include "ubx_nav_frame_parser_macros.svh"

module ubxnav_cmdq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  ubxnav_pkg::kind_t      push_kind,
    input  logic                   pop,
    output ubxnav_pkg::kind_t      pop_kind,
    output ubxnav_pkg::cmdq_stat_t stat
);

    localparam int DEPTH = ubxnav_pkg::CMDQ_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    ubxnav_pkg::kind_t entry_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [CW-1:0]     count_reg;

    assign stat.empty = (count_reg == CW'(0));
    assign stat.full  = (count_reg == CW'(DEPTH));
    assign pop_kind   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_kind;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    `UBXNAV_NEVER(a_cmdq_no_overflow, clk, rst_n, push && stat.full, "command pushed into full queue")
    `UBXNAV_NEVER(a_cmdq_no_underflow, clk, rst_n, pop && stat.empty, "command popped from empty queue")

endmodule

[design/ubxnav_store.sv]
`timescale 1ns / 1ps

module ubxnav_store #(
    parameter int STORE_BYTES = 512,
    localparam int AW = $clog2(STORE_BYTES),
    localparam int HW = $clog2(STORE_BYTES + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0]    mem [STORE_BYTES];
    logic [7:0]    rd_data_reg;
    logic          rd_zero_reg;
    // bytes below the high-water mark have been written since reset
    logic [HW-1:0] hwm_reg;

    assign rdata = rd_zero_reg ? 8'd0 : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hwm_reg     <= '0;
            rd_zero_reg <= 1'b1;
        end
        else
        begin
            rd_zero_reg <= (HW'(raddr) >= hwm_reg);
            if (we && (HW'(waddr) >= hwm_reg))
            begin
                hwm_reg <= HW'(waddr) + HW'(1);
            end
        end
    end

endmodule

[design/ubxnav_back.sv]
`timescale 1ns / 1ps
`include "ubx_nav_frame_parser_macros.svh"

module ubxnav_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    input  ubxnav_pkg::kind_t      cmd_kind,
    output logic                   cmd_pop,
    output ubxnav_pkg::off_t       rd_off,
    input  logic [7:0]             rd_data,
    output ubxnav_pkg::back_stat_t back_stat,
    input  logic [15:0]            course_wrap_speed,
    output logic                   out_valid,
    input  logic                   out_stall,
    output ubxnav_pkg::kind_t      update_kind,
    output logic signed [31:0]     longitude,
    output logic signed [30:0]     latitude,
    output logic signed [22:0]     altitude_m,
    output logic                   fix_3d,
    output logic [7:0]             satellites,
    output logic [15:0]            hdop,
    output logic [31:0]            ground_speed,
    output logic signed [12:0]     ground_course
);

    localparam int HQ = ubxnav_pkg::HEAD_Q_W;
    localparam int AQ = ubxnav_pkg::ALT_Q_W;

    typedef enum logic [2:0] {
        B_IDLE,
        B_READ,
        B_DRAIN,
        B_MUL,
        B_APPLY
    } b_state_t;

    b_state_t                state_reg;
    ubxnav_pkg::kind_t       kind_reg;
    ubxnav_pkg::slot_idx_t   idx_reg;
    ubxnav_pkg::slot_idx_t   cap_idx_reg;
    logic                    cap_valid_reg;
    logic [7:0]              slot_reg [ubxnav_pkg::SLOT_COUNT];
    logic [63:0]             prod_reg;
    logic                    neg_reg;
    logic                    out_valid_reg;
    ubxnav_pkg::kind_t       update_kind_reg;
    logic                    pending_fix_reg;
    logic                    held_fix_reg;
    logic signed [31:0]      held_lon_reg;
    logic signed [30:0]      held_lat_reg;
    logic signed [22:0]      held_alt_reg;
    logic [7:0]              held_sats_reg;
    logic [15:0]             held_hdop_reg;
    logic [31:0]             held_speed_reg;
    logic signed [12:0]      held_course_reg;

    logic [31:0]             src_word;
    logic [31:0]             src_mag;
    logic [31:0]             recip;
    logic [63:0]             prod_next;
    logic [AQ:0]             alt_mag;
    logic signed [AQ:0]      alt_next;
    logic [HQ:0]             head_mag;
    logic signed [HQ:0]      head_q;
    logic signed [HQ:0]      head_sat;
    logic signed [HQ:0]      head_next;
    logic [31:0]             speed_next;
    logic                    fix_next;
    logic                    apply_fire;

    assign cmd_pop           = (state_reg == B_IDLE) && cmd_valid;
    assign rd_off            = ubxnav_pkg::read_offset(kind_reg, idx_reg);
    assign back_stat.reading = (state_reg == B_READ) || (state_reg == B_DRAIN);
    assign apply_fire        = (state_reg == B_APPLY) && (!out_valid_reg || !out_stall);

    assign out_valid     = out_valid_reg;
    assign update_kind   = update_kind_reg;
    assign longitude     = held_lon_reg;
    assign latitude      = held_lat_reg;
    assign altitude_m    = held_alt_reg;
    assign fix_3d        = held_fix_reg;
    assign satellites    = held_sats_reg;
    assign hdop          = held_hdop_reg;
    assign ground_speed  = held_speed_reg;
    assign ground_course = held_course_reg;

    // signed field through the reciprocal multiplier, truncating toward zero
    always_comb
    begin
        if (kind_reg == ubxnav_pkg::KIND_POSLLH)
        begin
            src_word = {slot_reg[11], slot_reg[10], slot_reg[9], slot_reg[8]};
            recip    = ubxnav_pkg::RECIP_MM;
        end
        else
        begin
            src_word = {slot_reg[7], slot_reg[6], slot_reg[5], slot_reg[4]};
            recip    = ubxnav_pkg::RECIP_HEADING;
        end
        src_mag   = src_word[31] ? (~src_word + 32'd1) : src_word;
        prod_next = src_mag * recip;
    end

    always_comb
    begin
        alt_mag  = {1'b0, prod_reg[ubxnav_pkg::SHIFT_MM +: AQ]};
        alt_next = neg_reg ? ($signed((AQ + 1)'(0)) - $signed(alt_mag)) : $signed(alt_mag);

        head_mag = {1'b0, prod_reg[ubxnav_pkg::SHIFT_HEADING +: HQ]};
        head_q   = neg_reg ? ($signed((HQ + 1)'(0)) - $signed(head_mag)) : $signed(head_mag);
        if (head_q > ubxnav_pkg::COURSE_HI)
        begin
            head_sat = ubxnav_pkg::COURSE_HI;
        end
        else if (head_q < ubxnav_pkg::COURSE_LO)
        begin
            head_sat = ubxnav_pkg::COURSE_LO;
        end
        else
        begin
            head_sat = head_q;
        end

        speed_next = {slot_reg[3], slot_reg[2], slot_reg[1], slot_reg[0]};
        if ((speed_next > {16'd0, course_wrap_speed}) && (head_sat > ubxnav_pkg::COURSE_HALF))
        begin
            head_next = head_sat - ubxnav_pkg::COURSE_FULL;
        end
        else
        begin
            head_next = head_sat;
        end

        fix_next = slot_reg[1][0] && (slot_reg[0] == ubxnav_pkg::FIX_TYPE_3D);
    end

    always_ff @(posedge clk)
    begin
        if (cap_valid_reg)
        begin
            slot_reg[cap_idx_reg] <= rd_data;
        end
        if (state_reg == B_MUL)
        begin
            prod_reg <= prod_next;
            neg_reg  <= src_word[31];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= B_IDLE;
            kind_reg        <= ubxnav_pkg::KIND_POSLLH;
            idx_reg         <= '0;
            cap_idx_reg     <= '0;
            cap_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            update_kind_reg <= ubxnav_pkg::KIND_POSLLH;
            pending_fix_reg <= 1'b0;
            held_fix_reg    <= 1'b0;
            held_lon_reg    <= '0;
            held_lat_reg    <= '0;
            held_alt_reg    <= '0;
            held_sats_reg   <= '0;
            held_hdop_reg   <= '0;
            held_speed_reg  <= '0;
            held_course_reg <= '0;
        end
        else
        begin
            cap_valid_reg <= (state_reg == B_READ);
            cap_idx_reg   <= idx_reg;

            if (apply_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                B_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        kind_reg  <= cmd_kind;
                        idx_reg   <= '0;
                        state_reg <= B_READ;
                    end
                end
                B_READ:
                begin
                    idx_reg <= idx_reg + 4'd1;
                    if (idx_reg == ubxnav_pkg::read_last(kind_reg))
                    begin
                        state_reg <= B_DRAIN;
                    end
                end
                B_DRAIN:
                begin
                    state_reg <= B_MUL;
                end
                B_MUL:
                begin
                    state_reg <= B_APPLY;
                end
                B_APPLY:
                begin
                    if (apply_fire)
                    begin
                        state_reg       <= B_IDLE;
                        update_kind_reg <= kind_reg;
                        case (kind_reg)
                            ubxnav_pkg::KIND_POSLLH:
                            begin
                                held_lon_reg <= {slot_reg[3], slot_reg[2], slot_reg[1],
                                                 slot_reg[0]};
                                held_lat_reg <= {slot_reg[7][6:0], slot_reg[6], slot_reg[5],
                                                 slot_reg[4]};
                                held_alt_reg <= alt_next;
                                held_fix_reg <= pending_fix_reg;
                            end
                            ubxnav_pkg::KIND_STATUS:
                            begin
                                pending_fix_reg <= fix_next;
                                if (!fix_next)
                                begin
                                    held_fix_reg <= 1'b0;
                                end
                            end
                            ubxnav_pkg::KIND_SOL:
                            begin
                                pending_fix_reg <= fix_next;
                                if (!fix_next)
                                begin
                                    held_fix_reg <= 1'b0;
                                end
                                held_sats_reg <= slot_reg[4];
                                held_hdop_reg <= {slot_reg[3], slot_reg[2]};
                            end
                            ubxnav_pkg::KIND_VELNED:
                            begin
                                held_speed_reg  <= speed_next;
                                held_course_reg <= head_next[12:0];
                            end
                            default:
                            begin
                                held_fix_reg <= held_fix_reg;
                            end
                        endcase
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    `UBXNAV_IMPLY(a_back_out_from_apply, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == B_APPLY, "result word raised outside apply")

endmodule

[design/ubx_nav_frame_parser.sv]
// result path: the second check byte queues a command; the back end pops it, reads the store
//   once per field byte, then drains, multiplies and applies, waiting while a held word is stalled
// throughput: one byte word per cycle; payload bytes are held off while a command is queued
//   or fields are being read from the store, and the second check byte while the queue is full
// reset: rst_n asynchronous active low clears parser, queue and held values, registers
//   return to 464 and 100; payload store is not swept, unwritten bytes read as zero
`timescale 1ns / 1ps
`include "ubx_nav_frame_parser_macros.svh"

module ubx_nav_frame_parser #(
    parameter int STORE_BYTES = 512
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         update_kind,
    output logic signed [31:0] longitude,
    output logic signed [30:0] latitude,
    output logic signed [22:0] altitude_m,
    output logic               fix_3d,
    output logic [7:0]         satellites,
    output logic [15:0]        hdop,
    output logic [31:0]        ground_speed,
    output logic signed [12:0] ground_course
);

    localparam int AW = $clog2(STORE_BYTES);

    logic [9:0]             max_payload_reg;
    logic [15:0]            course_wrap_reg;

    ubxnav_pkg::cmdq_stat_t cmdq_stat;
    ubxnav_pkg::back_stat_t back_stat;
    logic                   cmd_push;
    ubxnav_pkg::kind_t      cmd_kind;
    logic                   cmd_pop;
    ubxnav_pkg::kind_t      pop_kind;
    logic                   st_we;
    logic [AW-1:0]          st_waddr;
    logic [7:0]             st_wdata;
    ubxnav_pkg::off_t       rd_off;
    logic [7:0]             st_rdata;
    ubxnav_pkg::kind_t      out_kind;

    assign update_kind = out_kind;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= ubxnav_pkg::MAX_PAYLOAD_RESET;
            course_wrap_reg <= ubxnav_pkg::COURSE_WRAP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ubxnav_pkg::REG_MAX_PAYLOAD: max_payload_reg <= cfg_data[9:0];
                ubxnav_pkg::REG_COURSE_WRAP: course_wrap_reg <= cfg_data;
                default:                     course_wrap_reg <= course_wrap_reg;
            endcase
        end
    end

    ubxnav_front #(
        .STORE_BYTES (STORE_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .max_payload (max_payload_reg),
        .cmdq_stat   (cmdq_stat),
        .back_stat   (back_stat),
        .cmd_push    (cmd_push),
        .cmd_kind    (cmd_kind),
        .st_we       (st_we),
        .st_waddr    (st_waddr),
        .st_wdata    (st_wdata)
    );

    ubxnav_cmdq u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_kind (cmd_kind),
        .pop       (cmd_pop),
        .pop_kind  (pop_kind),
        .stat      (cmdq_stat)
    );

    ubxnav_store #(
        .STORE_BYTES (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (AW'(rd_off)),
        .rdata (st_rdata)
    );

    ubxnav_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd_valid         (!cmdq_stat.empty),
        .cmd_kind          (pop_kind),
        .cmd_pop           (cmd_pop),
        .rd_off            (rd_off),
        .rd_data           (st_rdata),
        .back_stat         (back_stat),
        .course_wrap_speed (course_wrap_reg),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .update_kind       (out_kind),
        .longitude         (longitude),
        .latitude          (latitude),
        .altitude_m        (altitude_m),
        .fix_3d            (fix_3d),
        .satellites        (satellites),
        .hdop              (hdop),
        .ground_speed      (ground_speed),
        .ground_course     (ground_course)
    );

    `UBXNAV_NEVER(a_top_store_no_clash, clk, rst_n, st_we && back_stat.reading, "payload written while fields are read")

endmodule

[tb/ubx_nav_frame_parser_test.sv]
`timescale 1ns / 1ps

module ubx_nav_frame_parser_test;

    import ubxnav_pkg::*;

    localparam int DRAIN_CYCLES = 48;
    localparam int LEN_POSLLH = 28;
    localparam int LEN_STATUS = 16;
    localparam int LEN_SOL = 52;
    localparam int LEN_VELNED = 36;
    localparam int PRINT_CAP = 40;

    typedef logic [7:0] byte_q_t[$];

    typedef enum logic [3:0] {
        PS_HUNT    = 4'd0,
        PS_SYNC2   = 4'd1,
        PS_CLASS   = 4'd2,
        PS_ID      = 4'd3,
        PS_LEN_LO  = 4'd4,
        PS_LEN_HI  = 4'd5,
        PS_PAYLOAD = 4'd6,
        PS_CK_A    = 4'd7,
        PS_CK_B    = 4'd8
    } parse_step_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [31:0] lon;
        logic signed [30:0] lat;
        logic signed [22:0] alt;
        logic               fix;
        logic [7:0]         sats;
        logic [15:0]        hdop;
        logic [31:0]        speed;
        logic signed [12:0] course;
    } nav_word_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic               cfg_index = 1'b0;
    logic [15:0]        cfg_data = 16'h0000;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         data_byte = 8'h00;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         update_kind;
    logic signed [31:0] longitude;
    logic signed [30:0] latitude;
    logic signed [22:0] altitude_m;
    logic               fix_3d;
    logic [7:0]         satellites;
    logic [15:0]        hdop;
    logic [31:0]        ground_speed;
    logic signed [12:0] ground_course;

    int send_gap_pct = 17;
    int recv_stall_pct = 86;
    int mismatches = 0;
    int frame_bytes = 0;
    int updates_expected = 0;
    int updates_checked = 0;
    int reg_writes = 0;

    nav_word_t nav_expected[$];

    // parser mirror
    logic [9:0]  max_payload = MAX_PAYLOAD_RESET;
    logic [15:0] wrap_speed = COURSE_WRAP_RESET;
    parse_step_t parse_at = PS_HUNT;
    logic [7:0]  ck_a = 8'h00;
    logic [7:0]  ck_b = 8'h00;
    logic [7:0]  msg_id = 8'h00;
    logic [15:0] frame_len = 16'h0000;
    logic [9:0]  got_count = 10'd0;
    logic [7:0]  nav_store [0:511] = '{default: 8'h00};
    logic        pend_fix = 1'b0;
    logic        held_fix = 1'b0;
    logic [31:0] held_lon = 32'h0;
    logic [31:0] held_lat = 32'h0;
    int          held_alt = 0;
    logic [7:0]  held_sats = 8'h00;
    logic [15:0] held_hdop = 16'h0000;
    logic [31:0] held_speed = 32'h0;
    int          held_course = 0;

    ubx_nav_frame_parser u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_byte(data_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .update_kind(update_kind),
        .longitude(longitude),
        .latitude(latitude),
        .altitude_m(altitude_m),
        .fix_3d(fix_3d),
        .satellites(satellites),
        .hdop(hdop),
        .ground_speed(ground_speed),
        .ground_course(ground_course)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic logic [31:0] store_le32(int off);
        return {nav_store[off + 3], nav_store[off + 2], nav_store[off + 1], nav_store[off]};
    endfunction

    function automatic void add_fletcher(logic [7:0] value);
        ck_a = ck_a + value;
        ck_b = ck_b + ck_a;
    endfunction

    function automatic bit apply_nav_frame(output nav_word_t w);
        logic signed [31:0] raw;
        int q;
        bit known;
        kind_t kind;
        known = 1'b1;
        kind = KIND_POSLLH;
        case (msg_id)
            ID_POSLLH:
            begin
                held_lon = store_le32(4);
                held_lat = store_le32(8);
                raw = store_le32(16);
                held_alt = raw / 1000;
                held_fix = pend_fix;
            end
            ID_STATUS:
            begin
                pend_fix = nav_store[5][0] && (nav_store[4] == FIX_TYPE_3D);
                if (!pend_fix)
                begin
                    held_fix = 1'b0;
                end
                kind = KIND_STATUS;
            end
            ID_SOL:
            begin
                pend_fix = nav_store[11][0] && (nav_store[10] == FIX_TYPE_3D);
                if (!pend_fix)
                begin
                    held_fix = 1'b0;
                end
                held_sats = nav_store[47];
                held_hdop = {nav_store[45], nav_store[44]};
                kind = KIND_SOL;
            end
            ID_VELNED:
            begin
                held_speed = store_le32(20);
                raw = store_le32(24);
                q = raw / 10000;
                if (q > 3600)
                begin
                    q = 3600;
                end
                if (q < -1800)
                begin
                    q = -1800;
                end
                if (held_speed > {16'h0000, wrap_speed} && q > 1800)
                begin
                    q = q - 3600;
                end
                held_course = q;
                kind = KIND_VELNED;
            end
            default:
            begin
                known = 1'b0;
            end
        endcase
        w = '0;
        w.kind = kind;
        w.lon = held_lon;
        w.lat = held_lat[30:0];
        w.alt = held_alt[22:0];
        w.fix = held_fix;
        w.sats = held_sats;
        w.hdop = held_hdop;
        w.speed = held_speed;
        w.course = held_course[12:0];
        return known;
    endfunction

    function automatic bit parse_byte(input logic [7:0] value, output nav_word_t w);
        bit hit;
        hit = 1'b0;
        w = '0;
        case (parse_at)
            PS_SYNC2:
            begin
                if (value == SYNC_SECOND)
                begin
                    parse_at = PS_CLASS;
                end
                else
                begin
                    parse_at = (value == SYNC_FIRST) ? PS_SYNC2 : PS_HUNT;
                end
            end
            PS_CLASS:
            begin
                ck_a = value;
                ck_b = value;
                parse_at = PS_ID;
            end
            PS_ID:
            begin
                add_fletcher(value);
                msg_id = value;
                parse_at = PS_LEN_LO;
            end
            PS_LEN_LO:
            begin
                add_fletcher(value);
                frame_len = {8'h00, value};
                parse_at = PS_LEN_HI;
            end
            PS_LEN_HI:
            begin
                add_fletcher(value);
                frame_len = {value, frame_len[7:0]};
                got_count = 10'd0;
                if (frame_len > {6'd0, max_payload})
                begin
                    frame_len = 16'h0000;
                    parse_at = PS_HUNT;
                end
                else if (frame_len == 16'h0000)
                begin
                    parse_at = PS_CK_A;
                end
                else
                begin
                    parse_at = PS_PAYLOAD;
                end
            end
            PS_PAYLOAD:
            begin
                add_fletcher(value);
                if (got_count < 10'd512)
                begin
                    nav_store[got_count[8:0]] = value;
                end
                got_count = got_count + 10'd1;
                if ({6'd0, got_count} == frame_len)
                begin
                    parse_at = PS_CK_A;
                end
            end
            PS_CK_A:
            begin
                parse_at = (value == ck_a) ? PS_CK_B : PS_HUNT;
            end
            PS_CK_B:
            begin
                parse_at = PS_HUNT;
                if (value == ck_b)
                begin
                    hit = apply_nav_frame(w);
                end
            end
            default:
            begin
                parse_at = (value == SYNC_FIRST) ? PS_SYNC2 : PS_HUNT;
            end
        endcase
        return hit;
    endfunction

    function automatic byte_q_t make_frame(logic [7:0] cls, logic [7:0] id, logic [15:0] len,
                                           byte_q_t body);
        byte_q_t q;
        logic [7:0] sa;
        logic [7:0] sb;
        q.push_back(SYNC_FIRST);
        q.push_back(SYNC_SECOND);
        q.push_back(cls);
        q.push_back(id);
        q.push_back(len[7:0]);
        q.push_back(len[15:8]);
        foreach (body[i])
        begin
            q.push_back(body[i]);
        end
        sa = 8'h00;
        sb = 8'h00;
        for (int i = 2; i < q.size(); i++)
        begin
            sa = sa + q[i];
            sb = sb + sa;
        end
        q.push_back(sa);
        q.push_back(sb);
        return q;
    endfunction

    function automatic byte_q_t with_fields(int len, bit rand_fill,
                                            int off_a, logic [31:0] val_a,
                                            int off_b, logic [31:0] val_b,
                                            int off_c, logic [31:0] val_c);
        byte_q_t q;
        logic [7:0] raw [0:63];
        for (int i = 0; i < 64; i++)
        begin
            raw[i] = rand_fill ? 8'($urandom) : 8'h00;
        end
        {raw[off_a + 3], raw[off_a + 2], raw[off_a + 1], raw[off_a]} = val_a;
        {raw[off_b + 3], raw[off_b + 2], raw[off_b + 1], raw[off_b]} = val_b;
        {raw[off_c + 3], raw[off_c + 2], raw[off_c + 1], raw[off_c]} = val_c;
        for (int i = 0; i < len; i++)
        begin
            q.push_back((i < 64) ? raw[i] : (rand_fill ? 8'($urandom) : 8'h00));
        end
        return q;
    endfunction

    function automatic logic [31:0] pick_signed(int unsigned span);
        return $urandom_range(1) ? $urandom : $urandom_range(2 * span) - span;
    endfunction

    function automatic byte_q_t random_frame();
        logic [7:0] id;
        logic [7:0] cls;
        logic [7:0] fix_kind;
        logic [31:0] speed;
        int full_len;
        int len;
        byte_q_t body;
        case ($urandom_range(3))
            0:
            begin
                id = ID_POSLLH;
                full_len = LEN_POSLLH;
            end
            1:
            begin
                id = ID_STATUS;
                full_len = LEN_STATUS;
            end
            2:
            begin
                id = ID_SOL;
                full_len = LEN_SOL;
            end
            default:
            begin
                id = ID_VELNED;
                full_len = LEN_VELNED;
            end
        endcase
        len = full_len;
        if ($urandom_range(99) < 40)
        begin
            len = $urandom_range(full_len);
        end
        else if ($urandom_range(99) < 4)
        begin
            len = $urandom_range(512);
        end
        cls = ($urandom_range(3) == 0) ? 8'($urandom) : 8'h01;
        fix_kind = ($urandom_range(3) == 0) ? 8'($urandom_range(5)) : FIX_TYPE_3D;
        speed = $urandom_range(1) ? $urandom : {16'h0000, wrap_speed} + $urandom_range(2) - 1;
        case (id)
            ID_POSLLH:
            begin
                body = with_fields(len, 1'b1, 4, pick_signed(1800000000),
                                   8, pick_signed(900000000), 16, $urandom);
            end
            ID_STATUS:
            begin
                body = with_fields(len, 1'b1, 4, {16'($urandom), 8'($urandom), fix_kind},
                                   8, $urandom, 12, $urandom);
            end
            ID_SOL:
            begin
                body = with_fields(len, 1'b1, 8, {8'($urandom), fix_kind, 16'($urandom)},
                                   44, $urandom, 40, $urandom);
            end
            default:
            begin
                body = with_fields(len, 1'b1, 20, speed, 24, pick_signed(40000000),
                                   28, $urandom);
            end
        endcase
        return make_frame(cls, id, 16'(len), body);
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP)
        begin
            $display("mismatch at %0t: %s", $time, what);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
        end
    endtask

    task automatic send_byte(input logic [7:0] value);
        nav_word_t w;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= value;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        if (parse_byte(value, w))
        begin
            nav_expected.push_back(w);
            updates_expected++;
        end
    endtask

    task automatic send_bytes(input byte_q_t q);
        foreach (q[i])
        begin
            send_byte(q[i]);
            frame_bytes++;
        end
    endtask

    task automatic settle_idle();
        in_valid <= 1'b0;
        while (nav_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        settle_idle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_MAX_PAYLOAD)
        begin
            max_payload = value[9:0];
        end
        else
        begin
            wrap_speed = value;
        end
        reg_writes++;
    endtask

    task automatic send_velocity(input logic [31:0] speed, input logic [31:0] heading);
        send_bytes(make_frame(8'h01, ID_VELNED, 16'(LEN_VELNED),
                              with_fields(LEN_VELNED, 1'b0, 20, speed, 24, heading, 0, 32'h0)));
    endtask

    task automatic test_empty_payload();
        byte_q_t none;
        send_bytes(make_frame(8'h01, ID_POSLLH, 16'h0000, none));
        send_bytes(make_frame(8'h01, ID_STATUS, 16'h0000, none));
        send_bytes(make_frame(8'h01, ID_SOL, 16'h0000, none));
        send_bytes(make_frame(8'h01, ID_VELNED, 16'h0000, none));
        send_bytes(make_frame(8'h01, 8'h21, 16'h0000, none));
    endtask

    task automatic test_sync_recovery();
        send_byte(SYNC_FIRST);
        send_byte(8'h00);
        send_byte(SYNC_SECOND);
        send_byte(SYNC_FIRST);
        send_bytes(make_frame(8'h01, ID_STATUS, 16'd6,
                              with_fields(6, 1'b0, 4, {16'h0, 8'h01, FIX_TYPE_3D},
                                          0, 32'h0, 0, 32'h0)));
    endtask

    task automatic test_position_extremes();
        send_bytes(make_frame(8'h01, ID_POSLLH, 16'(LEN_POSLLH),
                              with_fields(LEN_POSLLH, 1'b0, 4, 32'd1800000000,
                                          8, -32'sd900000000, 16, -32'sd1999)));
        send_bytes(make_frame(8'h01, ID_POSLLH, 16'(LEN_POSLLH),
                              with_fields(LEN_POSLLH, 1'b0, 4, -32'sd1800000000,
                                          8, 32'd900000000, 16, 32'h7FFF_FFFF)));
        send_bytes(make_frame(8'h01, ID_POSLLH, 16'(LEN_POSLLH),
                              with_fields(LEN_POSLLH, 1'b0, 4, 32'hFFFF_FFFF,
                                          8, 32'h8000_0000, 16, 32'h8000_0000)));
    endtask

    task automatic test_solution_fix();
        send_bytes(make_frame(8'h01, ID_SOL, 16'(LEN_SOL),
                              with_fields(LEN_SOL, 1'b0, 8, {8'h01, FIX_TYPE_3D, 16'h0},
                                          44, 32'hFF00_FFFF, 0, 32'h0)));
        // short frame picks up older store contents
        send_bytes(make_frame(8'h01, ID_POSLLH, 16'd4,
                              with_fields(4, 1'b0, 0, 32'h1234_5678, 0, 32'h1234_5678,
                                          0, 32'h1234_5678)));
        send_bytes(make_frame(8'h01, ID_SOL, 16'(LEN_SOL),
                              with_fields(LEN_SOL, 1'b0, 8, {8'hFE, FIX_TYPE_3D, 16'h0},
                                          44, 32'h0, 0, 32'h0)));
        send_bytes(make_frame(8'h01, ID_STATUS, 16'd6,
                              with_fields(6, 1'b0, 4, {16'h0, 8'hFF, 8'd2}, 0, 32'h0, 0, 32'h0)));
    endtask

    task automatic test_course_wrap();
        send_velocity(32'd101, 32'd25000000);
        send_velocity(32'd100, 32'd25000000);
        send_velocity(32'd101, 32'h7FFF_FFFF);
        send_velocity(32'hFFFF_FFFF, 32'h8000_0000);
        send_velocity(32'hFFFF_FFFF, 32'd18010000);
        send_velocity(32'hFFFF_FFFF, 32'd18000000);
    endtask

    task automatic test_dropped_frames();
        byte_q_t q;
        byte_q_t none;
        q = make_frame(8'h01, ID_STATUS, 16'd6,
                       with_fields(6, 1'b0, 4, {16'h0, 8'h01, FIX_TYPE_3D}, 0, 32'h0, 0, 32'h0));
        q[q.size() - 2] = q[q.size() - 2] ^ 8'h01;
        send_bytes(q);
        q[q.size() - 2] = q[q.size() - 2] ^ 8'h01;
        q[q.size() - 1] = q[q.size() - 1] ^ 8'h80;
        send_bytes(q);
        send_bytes(make_frame(8'h01, 8'h01, 16'd8, with_fields(8, 1'b1, 0, 32'h0, 0, 32'h0,
                                                               0, 32'h0)));
        send_bytes(make_frame(8'h01, ID_POSLLH, 16'hFFFF, none));
        send_bytes(make_frame(8'h01, ID_POSLLH, 16'd465, none));
        send_bytes(make_frame(8'hFF, ID_STATUS, 16'd6,
                              with_fields(6, 1'b0, 4, {16'h0, 8'h01, FIX_TYPE_3D},
                                          0, 32'h0, 0, 32'h0)));
    endtask

    task automatic test_register_extremes();
        byte_q_t none;
        write_reg(REG_MAX_PAYLOAD, 16'd0);
        send_bytes(make_frame(8'h01, ID_POSLLH, 16'h0000, none));
        send_bytes(make_frame(8'h01, ID_STATUS, 16'd1, with_fields(1, 1'b1, 0, 32'h0, 0, 32'h0,
                                                                   0, 32'h0)));
        write_reg(REG_MAX_PAYLOAD, 16'd512);
        send_bytes(make_frame(8'h01, ID_SOL, 16'd512,
                              with_fields(512, 1'b1, 8, {8'h01, FIX_TYPE_3D, 16'h0},
                                          44, $urandom, 0, $urandom)));
        send_bytes(make_frame(8'h01, ID_STATUS, 16'd513,
                              with_fields(513, 1'b1, 0, 32'h0, 0, 32'h0, 0, 32'h0)));
        write_reg(REG_COURSE_WRAP, 16'd0);
        send_velocity(32'd1, 32'd20000000);
        send_velocity(32'd0, 32'd20000000);
        write_reg(REG_COURSE_WRAP, 16'hFFFF);
        send_velocity(32'd65535, 32'd20000000);
        send_velocity(32'd65536, 32'd20000000);
        write_reg(REG_MAX_PAYLOAD, 16'(MAX_PAYLOAD_RESET));
        write_reg(REG_COURSE_WRAP, COURSE_WRAP_RESET);
    endtask

    task automatic run_random_traffic(input int gap, input int stall, input logic [9:0] max_len,
                                      input logic [15:0] wrap);
        byte_q_t q;
        byte_q_t none;
        int bytes_goal;
        int updates_goal;
        int r;
        write_reg(REG_MAX_PAYLOAD, {6'd0, max_len});
        write_reg(REG_COURSE_WRAP, wrap);
        send_gap_pct = gap;
        recv_stall_pct = stall;
        bytes_goal = frame_bytes + 300;
        updates_goal = updates_expected + 12;
        while (frame_bytes < bytes_goal || updates_expected < updates_goal)
        begin
            r = $urandom_range(99);
            if (r < 8)
            begin
                repeat ($urandom_range(1, 6)) send_byte($urandom_range(1) ? SYNC_FIRST
                                                                           : 8'($urandom));
            end
            else if (r < 16)
            begin
                q = random_frame();
                if ($urandom_range(1))
                begin
                    r = q.size() - 1 - $urandom_range(1);
                    q[r] = q[r] ^ 8'(1 << $urandom_range(7));
                end
                else
                begin
                    q = q[0:$urandom_range(q.size() - 2)];
                end
                send_bytes(q);
            end
            else if (r < 18)
            begin
                send_bytes(make_frame(8'($urandom), 8'($urandom), 16'($urandom_range(60)),
                                      with_fields($urandom_range(60), 1'b1, 0, 32'h0,
                                                  0, 32'h0, 0, 32'h0)));
            end
            else if (r < 20)
            begin
                send_bytes(make_frame(8'h01, ID_POSLLH,
                                      16'(max_payload) + 16'($urandom_range(1, 600)), none));
            end
            else
            begin
                send_bytes(random_frame());
            end
        end
    endtask

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin : result_check
        nav_word_t want;
        if (out_valid && !out_stall)
        begin
            if (nav_expected.size() == 0)
            begin
                report_mismatch("navigation update word with none expected");
            end
            else
            begin
                want = nav_expected.pop_front();
                updates_checked++;
                check_field("update_kind", 32'(update_kind), 32'(want.kind));
                check_field("longitude", longitude, want.lon);
                check_field("latitude", latitude, want.lat);
                check_field("altitude_m", altitude_m, want.alt);
                check_field("fix_3d", 32'(fix_3d), 32'(want.fix));
                check_field("satellites", 32'(satellites), 32'(want.sats));
                check_field("hdop", 32'(hdop), 32'(want.hdop));
                check_field("ground_speed", ground_speed, want.speed);
                check_field("ground_course", ground_course, want.course);
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_payload();
        test_sync_recovery();
        test_position_extremes();
        test_solution_fix();
        test_course_wrap();
        test_dropped_frames();
        test_register_extremes();
        run_random_traffic(17, 86, 10'($urandom_range(64, 511)), 16'($urandom));
        run_random_traffic(86, 17, 10'd512, COURSE_WRAP_RESET);
        run_random_traffic(0, 0, MAX_PAYLOAD_RESET, 16'($urandom_range(400)));
        settle_idle();
        $display("covered %0d frame bytes and %0d checked navigation updates",
                 frame_bytes, updates_checked);
        $display("across %0d register writes and three sender/receiver idling patterns",
                 reg_writes);
        if (mismatches == 0 && nav_expected.size() == 0)
        begin
            $display("PASS ubx_nav_frame_parser");
        end
        else
        begin
            $display("FAIL ubx_nav_frame_parser");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("FAIL ubx_nav_frame_parser");
        $finish;
    end

endmodule
